### hw/rtl/rhsv_pkg.sv
// Package: shared types, constants and widths of the RGB to HSV converter.
package rhsv_pkg;

   localparam int unsigned CHAN_W        = 8;
   localparam int unsigned HUE_W         = 15;
   localparam int unsigned QUO_W         = 15;
   localparam int unsigned DIVR_W        = 9;
   localparam int unsigned HUE_NUM_W     = 24;
   localparam int unsigned SAT_NUM_W     = 17;
   localparam int unsigned NUM_CELLS     = QUO_W;
   localparam int unsigned HUE_SECTOR    = 3840;
   localparam int unsigned HUE_SCALE     = 2 * HUE_SECTOR;
   localparam int unsigned HUE_FULL_TURN = 23040;
   localparam int unsigned SAT_SCALE     = 510;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pix_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
   } hsv_type;

   // one division in flight: partial remainder, dividend bits shifting out
   // on the left while quotient bits shift in on the right
   typedef struct packed {
      logic [DIVR_W-1:0] rem;
      logic [QUO_W-1:0]  lo;
      logic [DIVR_W-1:0] divisor;
   } div_type;

   typedef struct packed {
      div_type           hue_div;
      div_type           sat_div;
      logic              grey;
      logic              black;
      logic [CHAN_W-1:0] brightness;
   } cell_data_type;

endpackage

### hw/rtl/rgb_to_hsv_converter_top.sv
// Top level: RGB to HSV converter, front stage followed by a chain of divider cells.
// Stages: 1 front + 15 cells; each cell resolves one quotient bit of both divisions.
// Throughput: one transaction per cycle while rsp_ready is high.
// A stage holds its transaction only while its successor cannot take it; empty stages fill.
// Reset (synchronous) clears all stage valid bits; payload registers are not reset.
module rgb_to_hsv_converter_top import rhsv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  pix_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output hsv_type rsp_data
);

   logic          stg_valid [NUM_CELLS+1];
   logic          stg_en    [NUM_CELLS+1];
   cell_data_type stg_data  [NUM_CELLS+1];
   cell_data_type last;
   logic [HUE_W-1:0] hue_q;

   rhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (stg_valid[0]),
      .out_en    (stg_en[0]),
      .out_data  (stg_data[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      rhsv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[i]),
         .in_ready  (stg_en[i]),
         .in_data   (stg_data[i]),
         .out_valid (stg_valid[i+1]),
         .out_en    (stg_en[i+1]),
         .out_data  (stg_data[i+1])
      );
   end

   assign stg_en[NUM_CELLS] = rsp_ready;
   assign last              = stg_data[NUM_CELLS];
   assign hue_q             = last.hue_div.lo;

   always_comb begin
      rsp_valid           = stg_valid[NUM_CELLS];
      rsp_data.brightness = last.brightness;
      rsp_data.saturation = last.black ? '0 : last.sat_div.lo[CHAN_W-1:0];
      if (last.grey) begin
         rsp_data.hue = '0;
      end else if (hue_q >= HUE_W'(HUE_FULL_TURN)) begin
         rsp_data.hue = hue_q - HUE_W'(HUE_FULL_TURN);
      end else begin
         rsp_data.hue = hue_q;
      end
   end

endmodule

### hw/rtl/rhsv_front.sv
// Front stage: max/min, hue sector selection and setup of both divisions.
module rhsv_front import rhsv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  pix_type       in_data,
   output logic          out_valid,
   input  logic          out_en,
   output cell_data_type out_data
);

   logic                  valid_ff;
   logic                  valid_in;
   cell_data_type         data_ff;
   cell_data_type         data_in;

   logic [CHAN_W-1:0]     mx;
   logic [CHAN_W-1:0]     mn;
   logic [CHAN_W-1:0]     d;
   logic signed [11:0]    m_s;
   logic [10:0]           m;
   logic [HUE_NUM_W-1:0]  hue_num;
   logic [SAT_NUM_W-1:0]  sat_num;

   always_comb begin
      mx = in_data.red;
      if (in_data.green > mx) mx = in_data.green;
      if (in_data.blue > mx) mx = in_data.blue;
      mn = in_data.red;
      if (in_data.green < mn) mn = in_data.green;
      if (in_data.blue < mn) mn = in_data.blue;
      d = mx - mn;

      if (in_data.red == mx) begin
         m_s = $signed({4'b0, in_data.green}) - $signed({4'b0, in_data.blue});
      end else if (in_data.green == mx) begin
         m_s = $signed({3'b0, d, 1'b0}) + $signed({4'b0, in_data.blue})
             - $signed({4'b0, in_data.red});
      end else begin
         m_s = $signed({2'b0, d, 2'b0}) + $signed({4'b0, in_data.red})
             - $signed({4'b0, in_data.green});
      end
      if (m_s < 0) begin
         m_s = m_s + $signed({2'b0, d, 2'b0}) + $signed({3'b0, d, 1'b0});
      end
      m = m_s[10:0];

      hue_num = HUE_NUM_W'(m) * HUE_NUM_W'(HUE_SCALE) + HUE_NUM_W'(d);
      sat_num = SAT_NUM_W'(SAT_SCALE) * SAT_NUM_W'(d) + SAT_NUM_W'(mx);

      data_in.hue_div.rem     = hue_num[HUE_NUM_W-1 -: DIVR_W];
      data_in.hue_div.lo      = hue_num[QUO_W-1:0];
      data_in.hue_div.divisor = {d, 1'b0};
      data_in.sat_div.rem     = DIVR_W'(sat_num[SAT_NUM_W-1:QUO_W]);
      data_in.sat_div.lo      = sat_num[QUO_W-1:0];
      data_in.sat_div.divisor = {mx, 1'b0};
      data_in.grey            = (d == '0);
      data_in.black           = (mx == '0);
      data_in.brightness      = mx;
   end

   assign in_ready = !valid_ff || out_en;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hw/rtl/rhsv_cell.sv
// Divider cell: one restoring step of the hue and saturation divisions.
module rhsv_cell import rhsv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  cell_data_type in_data,
   output logic          out_valid,
   input  logic          out_en,
   output cell_data_type out_data
);

   logic          valid_ff;
   logic          valid_in;
   cell_data_type data_ff;
   cell_data_type data_in;

   function automatic div_type div_step(input div_type x);
      logic [DIVR_W:0] t;
      logic [DIVR_W:0] dv;
      logic            q;
      div_type         y;
      t  = {x.rem, x.lo[QUO_W-1]};
      dv = {1'b0, x.divisor};
      q  = (t >= dv);
      if (q) begin
         t = t - dv;
      end
      y.rem     = t[DIVR_W-1:0];
      y.lo      = {x.lo[QUO_W-2:0], q};
      y.divisor = x.divisor;
      return y;
   endfunction

   always_comb begin
      data_in         = in_data;
      data_in.hue_div = div_step(in_data.hue_div);
      data_in.sat_div = div_step(in_data.sat_div);
   end

   assign in_ready = !valid_ff || out_en;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hw/rtl/rhsv_checker.sv
// Checker: port-level assertions for the RGB to HSV converter, bound to the top level.
module rhsv_checker import rhsv_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input pix_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input hsv_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction dropped or changed while stalled");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.hue < HUE_W'(HUE_FULL_TURN))
      else $error("hue out of range");

   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.brightness == '0 |->
         rsp_data.saturation == '0 && rsp_data.hue == '0)
      else $error("black pixel with nonzero hue or saturation");

   a_grey: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturation == '0 |-> rsp_data.hue == '0)
      else $error("zero saturation with nonzero hue");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid right after reset");

endmodule

bind rgb_to_hsv_converter_top rhsv_checker u_rhsv_checker (.*);

### dv/hsv_checker.sv
// Checker: watches both channels of the RGB to HSV converter, predicts and compares results.
module hsv_checker import rhsv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  pix_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  hsv_type rsp_data,
   output int      fail_count,
   output int      pending
);

   hsv_type expected_hsv[$];

   function automatic hsv_type rgb_to_hsv(pix_type p);
      int r, g, b, mx, mn, d, k, n, num, hue, sat;
      hsv_type res;
      r = p.red;
      g = p.green;
      b = p.blue;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      hue = 0;
      sat = 0;
      if (mx != 0) begin
         d = mx - mn;
         sat = (int'(SAT_SCALE) * d + mx) / (2 * mx);
         if (d != 0) begin
            // sector priority: red, then green, then blue
            if (r == mx) begin
               k = 0;
               n = g - b;
            end else if (g == mx) begin
               k = 2;
               n = b - r;
            end else begin
               k = 4;
               n = r - g;
            end
            num = int'(HUE_SECTOR) * (k * d + n);
            if (num < 0) num += int'(HUE_FULL_TURN) * d;
            hue = (2 * num + d) / (2 * d);
            if (hue >= int'(HUE_FULL_TURN)) hue -= int'(HUE_FULL_TURN);
         end
      end
      res.hue        = hue[HUE_W-1:0];
      res.saturation = sat[CHAN_W-1:0];
      res.brightness = mx[CHAN_W-1:0];
      return res;
   endfunction

   initial fail_count = 0;

   assign pending = expected_hsv.size();

   always @(posedge clock) begin
      hsv_type exp_hsv;
      if (!reset) begin
         if (req_valid && req_ready) expected_hsv.push_back(rgb_to_hsv(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_hsv.size() == 0) begin
               $error("unexpected transaction on rsp_: hue %0d saturation %0d brightness %0d",
                      rsp_data.hue, rsp_data.saturation, rsp_data.brightness);
               fail_count = fail_count + 1;
            end else begin
               exp_hsv = expected_hsv.pop_front();
               if (rsp_data.hue !== exp_hsv.hue) begin
                  $error("hue mismatch: expected %0d, actual %0d", exp_hsv.hue, rsp_data.hue);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.saturation !== exp_hsv.saturation) begin
                  $error("saturation mismatch: expected %0d, actual %0d",
                         exp_hsv.saturation, rsp_data.saturation);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.brightness !== exp_hsv.brightness) begin
                  $error("brightness mismatch: expected %0d, actual %0d",
                         exp_hsv.brightness, rsp_data.brightness);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### dv/tb_top.sv
// Testbench top: clock, reset, pixel stimulus and result back-pressure for the converter.
module tb_top;
   import rhsv_pkg::*;

   localparam int NUM_RANDOM   = 1330;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   pix_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   hsv_type rsp_data;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int tx_burst    = 0;
   int rx_burst    = 0;
   int rx_stall    = 0;

   logic [23:0] directed_pix [] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
      24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h010000, 24'h000001,
      24'h000100, 24'hFF0001, 24'hFE00FF, 24'h8080FF, 24'h7F7F80, 24'hFFFEFF,
      24'h01FF00, 24'h55AA00, 24'h123456, 24'hABCDEF, 24'hFF8000
   };

   always #2 clock = ~clock;

   rgb_to_hsv_converter_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   hsv_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   function automatic pix_type random_pixel();
      pix_type p;
      int base;
      p = pix_type'(24'($urandom));
      case ($urandom_range(0, 9))
         6: begin
            // two channels tied
            case ($urandom_range(0, 2))
               0: p.green = p.red;
               1: p.blue = p.red;
               default: p.blue = p.green;
            endcase
         end
         7: begin
            p.green = p.red;
            p.blue  = p.red;
         end
         8: begin
            // narrow spread
            base    = $urandom_range(0, 252);
            p.red   = CHAN_W'(base + $urandom_range(0, 3));
            p.green = CHAN_W'(base + $urandom_range(0, 3));
            p.blue  = CHAN_W'(base + $urandom_range(0, 3));
         end
         9: begin
            if ($urandom_range(0, 1)) p.red = '1; else p.red = '0;
            if ($urandom_range(0, 1)) p.blue = '1;
            else if ($urandom_range(0, 1)) p.green = '0;
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic send_pixel(input pix_type p);
      int gap;
      if (tx_burst > 0) begin
         tx_burst--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 49) == 0) tx_burst = $urandom_range(30, 100);
         gap = $urandom_range(0, 15);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      int stall_draw;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_stall  <= 0;
      end else if (rsp_ready && rsp_valid) begin
         if (rx_burst > 0) begin
            rx_burst <= rx_burst - 1;
         end else if ($urandom_range(0, 40) == 0) begin
            rx_burst <= $urandom_range(20, 80);
         end else begin
            stall_draw = $urandom_range(0, 15);
            rx_stall <= stall_draw;
            if (stall_draw > 0) rsp_ready <= 1'b0;
         end
      end else if (!rsp_ready) begin
         if (rx_stall == 0) rsp_ready <= 1'b1;
         else rx_stall <= rx_stall - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_pix[i]) send_pixel(pix_type'(directed_pix[i]));
      repeat (NUM_RANDOM) send_pixel(random_pixel());
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
